/* sv/icec_pkg.sv */
// ---------------------------------------------------------------------------
// icec_pkg: shared types and constants for the incidence column edge checker
// Field widths, entry codes, column status codes and the structs that pass
// between the column accumulator, the column evaluator and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package icec_pkg;

	localparam int ENTRY_W = 8;
	localparam int VTX_W   = 8;
	localparam int ROW_W   = 9;
	localparam int COL_W   = 11;
	localparam int CNT_W   = 2;

	localparam logic [VTX_W-1:0] VTX_MAX = {VTX_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// incidence entry codes
	localparam logic signed [ENTRY_W-1:0] ENTRY_PLUS  = 8'sd1;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MINUS = -8'sd1;
	localparam logic signed [ENTRY_W-1:0] ENTRY_LOOP  = 8'sd2;
	localparam logic signed [ENTRY_W-1:0] ENTRY_ZERO  = 8'sd0;

	typedef enum logic [2:0] {
		ST_EDGE    = 3'd0,
		ST_LOOP    = 3'd1,
		ST_INVALID = 3'd2,
		ST_MIXED   = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_BADCOMB = 3'd5,
		ST_AFTER   = 3'd6
	} status_t;

	// running state of the column being scanned
	typedef struct packed {
		logic [CNT_W-1:0] unit_count;
		logic [CNT_W-1:0] loop_count;
		logic [VTX_W-1:0] first_row;
		logic [VTX_W-1:0] second_row;
		logic [VTX_W-1:0] minus_row;
		logic             minus_seen;
		logic             invalid;
		logic             loop_row_set;
	} col_state_t;

	// one result item
	typedef struct packed {
		status_t          status;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;
		logic             dir;
		logic             done;
		logic             g_directed;
		logic             g_tree;
		logic             g_valid;
	} result_t;

endpackage

`default_nettype wire

/* sv/icec_if.sv */
// ---------------------------------------------------------------------------
// icec_if: valid/ready channels of the incidence column edge checker
// Entry channel (one matrix entry per item) and result channel (one column
// result per item).
// ---------------------------------------------------------------------------
`default_nettype none

interface icec_entry_if;
	import icec_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ENTRY_W-1:0] entry;
	logic                      end_of_column;
	logic                      end_of_graph;

	modport source (output valid, entry, end_of_column, end_of_graph, input ready);
	modport sink   (input valid, entry, end_of_column, end_of_graph, output ready);
endinterface

interface icec_result_if;
	import icec_pkg::*;

	logic             valid;
	logic             ready;
	status_t          column_status;
	logic [VTX_W-1:0] source_vertex;
	logic [VTX_W-1:0] target_vertex;
	logic             edge_directed;
	logic             graph_done;
	logic             graph_directed;
	logic             graph_is_tree;
	logic             graph_valid;

	modport source (output valid, column_status, source_vertex, target_vertex,
		edge_directed, graph_done, graph_directed, graph_is_tree, graph_valid,
		input ready);
	modport sink   (input valid, column_status, source_vertex, target_vertex,
		edge_directed, graph_done, graph_directed, graph_is_tree, graph_valid,
		output ready);
endinterface

`default_nettype wire

/* sv/icec_column_acc.sv */
// ---------------------------------------------------------------------------
// icec_column_acc: per-column entry accumulator
// Classifies each entry, folds it into the column state and keeps the row
// counter. Presents the column state including the current entry.
// ---------------------------------------------------------------------------
`default_nettype none

module icec_column_acc #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic signed [icec_pkg::ENTRY_W-1:0] entry,
	input  logic                              end_of_column,
	output icec_pkg::col_state_t              col_next,
	output logic [icec_pkg::ROW_W-1:0]        rows
);
	import icec_pkg::*;

	localparam int               ROW_LIMIT_I = (MAX_VERTICES < 511) ? MAX_VERTICES : 511;
	localparam logic [ROW_W-1:0] ROW_LIMIT   = ROW_W'(ROW_LIMIT_I);

	col_state_t       col_q;
	logic [ROW_W-1:0] row_q;
	logic [VTX_W-1:0] vrow;
	logic             is_unit;
	logic             is_two;

	assign vrow    = (row_q > ROW_W'(VTX_MAX)) ? VTX_MAX : row_q[VTX_W-1:0];
	assign is_unit = (entry == ENTRY_PLUS) || (entry == ENTRY_MINUS);
	assign is_two  = (entry == ENTRY_LOOP);
	assign rows    = (row_q < ROW_LIMIT) ? row_q + ROW_W'(1) : ROW_LIMIT;

	always_comb begin
		col_next = col_q;
		if (is_unit) begin
			if (col_q.unit_count == CNT_W'(0)) begin
				col_next.first_row = vrow;
			end else if (col_q.unit_count == CNT_W'(1)) begin
				col_next.second_row = vrow;
			end
			if (col_q.unit_count != CNT_MAX) begin
				col_next.unit_count = col_q.unit_count + CNT_W'(1);
			end
			if (entry == ENTRY_MINUS) begin
				col_next.minus_seen = 1'b1;
				col_next.minus_row  = vrow;
			end
		end else if (is_two) begin
			if (col_q.unit_count == CNT_W'(0) && !col_q.loop_row_set) begin
				col_next.first_row    = vrow;
				col_next.loop_row_set = 1'b1;
			end
			if (col_q.loop_count != CNT_MAX) begin
				col_next.loop_count = col_q.loop_count + CNT_W'(1);
			end
		end else if (entry != ENTRY_ZERO) begin
			col_next.invalid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_of_column) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				col_q <= col_next;
				row_q <= rows;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/icec_column_eval.sv */
// ---------------------------------------------------------------------------
// icec_column_eval: column classification and graph summary
// Turns a closed column into a status and endpoints, and keeps the column
// counter and graph flags until the end of the graph.
// ---------------------------------------------------------------------------
`default_nettype none

module icec_column_eval #(
	parameter int MAX_EDGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       close,
	input  logic                       end_of_graph,
	input  icec_pkg::col_state_t       col,
	input  logic [icec_pkg::ROW_W-1:0] rows,
	output icec_pkg::result_t          result
);
	import icec_pkg::*;

	localparam int               COL_LIMIT_I = (MAX_EDGES < 2047) ? MAX_EDGES : 2047;
	localparam logic [COL_W-1:0] COL_LIMIT   = COL_W'(COL_LIMIT_I);

	logic [COL_W-1:0] col_cnt_q;
	logic             g_dir_q;
	logic             g_loop_q;
	logic             g_err_q;

	logic [COL_W-1:0] cols_n;
	logic             g_dir_n;
	logic             g_loop_n;
	logic             g_err_n;
	status_t          status;
	logic             swap;

	assign cols_n = (col_cnt_q < COL_LIMIT) ? col_cnt_q + COL_W'(1) : col_cnt_q;
	assign swap   = col.minus_seen && (col.first_row == col.minus_row)
		&& (col.second_row != col.minus_row);

	always_comb begin
		if (col.invalid) begin
			status = ST_INVALID;
		end else if (col.unit_count != '0 && col.loop_count != '0) begin
			status = ST_MIXED;
		end else if (col.unit_count == '0 && col.loop_count == '0) begin
			status = ST_EMPTY;
		end else if (col.unit_count == CNT_W'(2) && col.loop_count == '0) begin
			status = ST_EDGE;
		end else if (col.unit_count == '0 && col.loop_count == CNT_W'(1)) begin
			status = ST_LOOP;
		end else begin
			status = ST_BADCOMB;
		end
	end

	always_comb begin
		result   = '0;
		g_dir_n  = g_dir_q;
		g_loop_n = g_loop_q;
		g_err_n  = g_err_q;
		if (g_err_q) begin
			result.status = ST_AFTER;
		end else begin
			result.status = status;
			g_dir_n  = g_dir_q | col.minus_seen;
			g_loop_n = g_loop_q | (col.loop_count != '0);
			case (status)
				ST_EDGE: begin
					result.dir = col.minus_seen;
					result.src = swap ? col.second_row : col.first_row;
					result.dst = swap ? col.first_row : col.second_row;
				end
				ST_LOOP: begin
					result.src = col.first_row;
					result.dst = col.first_row;
				end
				default: begin
					g_err_n = 1'b1;
				end
			endcase
		end
		if (end_of_graph) begin
			result.done       = 1'b1;
			result.g_directed = g_dir_n;
			result.g_valid    = !g_err_n;
			result.g_tree     = !g_err_n && !g_loop_n
				&& (COL_W'(rows - ROW_W'(1)) == cols_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			g_dir_q   <= 1'b0;
			g_loop_q  <= 1'b0;
			g_err_q   <= 1'b0;
		end else if (close) begin
			if (end_of_graph) begin
				col_cnt_q <= '0;
				g_dir_q   <= 1'b0;
				g_loop_q  <= 1'b0;
				g_err_q   <= 1'b0;
			end else begin
				col_cnt_q <= cols_n;
				g_dir_q   <= g_dir_n;
				g_loop_q  <= g_loop_n;
				g_err_q   <= g_err_n;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/incidence_column_edge_checker.sv */
// ---------------------------------------------------------------------------
// incidence_column_edge_checker: incidence matrix column checker
// Streams a graph's incidence matrix column by column and gives one result
// item per column, plus graph summary flags on the last column.
// ---------------------------------------------------------------------------
// Usage: send the matrix one entry per item, column-major, with
// end_of_column on the last row of each column and end_of_graph together
// with end_of_column on the last column. The block takes one entry item per
// cycle with no bubbles while no result is held; an entry is registered,
// folded into the column state in the following cycle, and a column's result
// item is registered when its closing entry leaves the input register. Entries
// that do not close a column produce no result. The only thing that stalls
// the entry channel is a held result: a closing entry waits in the input
// register while the result register is full and not being taken. Row and
// column counts saturate at min(MAX_VERTICES, 511) and min(MAX_EDGES, 2047);
// vertex numbers saturate at 255. After a column error every later column of
// the same graph reports "after error" with zero endpoints.
`default_nettype none

module incidence_column_edge_checker #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_EDGES    = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	icec_entry_if.sink           entry_ch,
	icec_result_if.source        result_ch
);
	import icec_pkg::*;

	// input register stage
	logic                      valid_s1;
	logic signed [ENTRY_W-1:0] entry_s1;
	logic                      eoc_s1;
	logic                      eog_s1;

	// result register
	logic                      out_valid_q;
	result_t                   res_q;

	logic                      out_free;
	logic                      advance;
	logic                      close;
	logic                      in_fire;
	col_state_t                col_next;
	logic [ROW_W-1:0]          rows;
	result_t                   result;

	// The result slot is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || result_ch.ready;
	// A non-closing entry never waits; a closing one needs the result slot.
	assign advance  = valid_s1 && (!eoc_s1 || out_free);
	assign close    = advance && eoc_s1;
	assign entry_ch.ready = !valid_s1 || advance;
	assign in_fire  = entry_ch.valid && entry_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			entry_s1 <= entry_ch.entry;
			eoc_s1   <= entry_ch.end_of_column;
			eog_s1   <= entry_ch.end_of_graph;
		end
	end

	// column state: counts, marked rows, row counter
	icec_column_acc #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.entry         (entry_s1),
		.end_of_column (eoc_s1),
		.col_next      (col_next),
		.rows          (rows)
	);

	// classification, endpoints, graph flags
	icec_column_eval #(
		.MAX_EDGES (MAX_EDGES)
	) u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.close        (close),
		.end_of_graph (eog_s1),
		.col          (col_next),
		.rows         (rows),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (close) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			res_q <= result;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.column_status  = res_q.status;
	assign result_ch.source_vertex  = res_q.src;
	assign result_ch.target_vertex  = res_q.dst;
	assign result_ch.edge_directed  = res_q.dir;
	assign result_ch.graph_done     = res_q.done;
	assign result_ch.graph_directed = res_q.g_directed;
	assign result_ch.graph_is_tree  = res_q.g_tree;
	assign result_ch.graph_valid    = res_q.g_valid;

endmodule

`default_nettype wire

/* test/incidence_column_edge_checker_tb.sv */
// ---------------------------------------------------------------------------
// incidence_column_edge_checker_tb: self-checking bench for the column checker
// Sends a short table of directed matrix entries, then random graphs built
// mostly from well-formed edge and loop columns. Random idles sit on both
// channels. Every column result is checked field by field against the
// directed table's typed values or a predictor that runs in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module incidence_column_edge_checker_tb;
	import icec_pkg::*;

	localparam int MAX_VERTICES = 256;
	localparam int MAX_EDGES    = 1024;
	localparam int ROW_LIMIT    = (MAX_VERTICES < 511) ? MAX_VERTICES : 511;
	localparam int COL_LIMIT    = (MAX_EDGES < 2047) ? MAX_EDGES : 2047;

	localparam int NUM_DIRECTED  = 20;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int IDLE_PCT      = 19;
	// no idling on either side while this range of items goes through
	localparam int QUIET_FIRST   = 600;
	localparam int QUIET_LAST    = 800;
	localparam int REPORT_LIMIT  = 40;

	localparam result_t NO_RESULT = '0;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic signed [ENTRY_W-1:0] entry;
		bit                        eoc;
		bit                        eog;
		bit                        typed;
		result_t                   want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	icec_entry_if  entry_ch ();
	icec_result_if result_ch ();

	incidence_column_edge_checker #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry_ch (entry_ch),
		.result_ch(result_ch)
	);

	always #2 clk = ~clk;

	// Directed part. Result fields:
	// status, src, dst, dir, done, graph directed, graph tree, graph valid.
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		// graph of three columns: forward edge, reversed edge, loop on row 1
		'{ 8'sd1,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{-8'sd1,  1'b1, 1'b0, 1'b1, '{ST_EDGE, 8'd0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{-8'sd1,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ 8'sd1,  1'b1, 1'b0, 1'b1, '{ST_EDGE, 8'd1, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ 8'sd0,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ 8'sd2,  1'b1, 1'b1, 1'b1, '{ST_LOOP, 8'd1, 8'd1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
		// single empty column
		'{ 8'sd0,  1'b1, 1'b1, 1'b1, '{ST_EMPTY, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// top positive value is invalid, then the next column reports after error
		'{ 8'sd127, 1'b1, 1'b0, 1'b1, '{ST_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ 8'sd1,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ 8'sd1,  1'b1, 1'b1, 1'b1, '{ST_AFTER, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// unit plus loop mark is mixed; most negative entry lands after error
		'{ 8'sd1,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ 8'sd2,  1'b1, 1'b0, 1'b1, '{ST_MIXED, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{-8'sd128, 1'b1, 1'b1, 1'b1, '{ST_AFTER, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// lone unit entry is a bad combination
		'{ 8'sd1,  1'b1, 1'b1, 1'b1, '{ST_BADCOMB, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
		// three rows, two columns: a directed tree; stray graph end on the first row,
		// and the second column carries two minus-ones
		'{ 8'sd1,  1'b0, 1'b1, 1'b0, NO_RESULT},
		'{-8'sd1,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{ 8'sd0,  1'b1, 1'b0, 1'b1, '{ST_EDGE, 8'd0, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ 8'sd0,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{-8'sd1,  1'b0, 1'b0, 1'b0, NO_RESULT},
		'{-8'sd1,  1'b1, 1'b1, 1'b1, '{ST_EDGE, 8'd1, 8'd2, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}}
	};

	// predictor state: the open column
	int                row_cnt    = 0;
	int                unit_cnt   = 0;
	int                loop_cnt   = 0;
	logic [VTX_W-1:0]  first_row  = '0;
	logic [VTX_W-1:0]  second_row = '0;
	logic [VTX_W-1:0]  minus_row  = '0;
	bit                minus_seen   = 1'b0;
	bit                bad_value    = 1'b0;
	bit                loop_row_set = 1'b0;
	// predictor state: the open graph
	int                col_cnt  = 0;
	bit                g_dir    = 1'b0;
	bit                g_loop   = 1'b0;
	bit                g_err    = 1'b0;

	result_t pending_verdicts [$];

	int  items_sent    = 0;
	int  columns_seen  = 0;
	int  graphs_seen   = 0;
	int  mismatches    = 0;
	int  cycles        = 0;
	bit  quiet;

	assign quiet = (items_sent >= QUIET_FIRST) && (items_sent < QUIET_LAST);

	// Folds one entry into the column state. When the entry closes a column,
	// returns the column verdict and rolls the graph state.
	task automatic column_verdict(input logic signed [ENTRY_W-1:0] e, input bit eoc,
		input bit eog, output bit closes, output result_t r);
		int vrow;
		int rows;
		r = NO_RESULT;
		closes = eoc;
		vrow = (row_cnt < 255) ? row_cnt : 255;
		rows = (row_cnt < ROW_LIMIT) ? row_cnt + 1 : ROW_LIMIT;

		if (e == ENTRY_PLUS || e == ENTRY_MINUS) begin
			if (unit_cnt == 0)
				first_row = VTX_W'(vrow);
			else if (unit_cnt == 1)
				second_row = VTX_W'(vrow);
			if (unit_cnt < 3)
				unit_cnt++;
			if (e == ENTRY_MINUS) begin
				minus_seen = 1'b1;
				minus_row = VTX_W'(vrow);
			end
		end else if (e == ENTRY_LOOP) begin
			if (unit_cnt == 0 && !loop_row_set) begin
				first_row = VTX_W'(vrow);
				loop_row_set = 1'b1;
			end
			if (loop_cnt < 3)
				loop_cnt++;
		end else if (e != ENTRY_ZERO) begin
			bad_value = 1'b1;
		end

		if (!eoc) begin
			row_cnt = rows;
		end else begin
			if (g_err) begin
				r.status = ST_AFTER;
			end else begin
				if (minus_seen)
					g_dir = 1'b1;
				if (loop_cnt != 0)
					g_loop = 1'b1;
				// invalid beats mixed, mixed beats empty
				if (bad_value)
					r.status = ST_INVALID;
				else if (unit_cnt != 0 && loop_cnt != 0)
					r.status = ST_MIXED;
				else if (unit_cnt == 0 && loop_cnt == 0)
					r.status = ST_EMPTY;
				else if (unit_cnt == 2 && loop_cnt == 0)
					r.status = ST_EDGE;
				else if (unit_cnt == 0 && loop_cnt == 1)
					r.status = ST_LOOP;
				else
					r.status = ST_BADCOMB;

				if (r.status == ST_EDGE) begin
					r.dir = minus_seen;
					// the plus-one row is the source; two minus-ones keep row order
					if (minus_seen && first_row == minus_row && second_row != minus_row) begin
						r.src = second_row;
						r.dst = first_row;
					end else begin
						r.src = first_row;
						r.dst = second_row;
					end
				end else if (r.status == ST_LOOP) begin
					r.src = first_row;
					r.dst = first_row;
				end else begin
					g_err = 1'b1;
				end
			end

			if (col_cnt < COL_LIMIT)
				col_cnt++;
			if (eog) begin
				r.done = 1'b1;
				r.g_directed = g_dir;
				r.g_valid = !g_err;
				r.g_tree = !g_err && !g_loop && (rows - 1 == col_cnt);
				col_cnt = 0;
				g_dir = 1'b0;
				g_loop = 1'b0;
				g_err = 1'b0;
			end

			row_cnt = 0;
			unit_cnt = 0;
			loop_cnt = 0;
			first_row = '0;
			second_row = '0;
			minus_row = '0;
			minus_seen = 1'b0;
			bad_value = 1'b0;
			loop_row_set = 1'b0;
		end
	endtask

	// Drives one entry item, waits for it to be taken and predicts its effect.
	task automatic send_entry(input logic signed [ENTRY_W-1:0] e, input bit eoc,
		input bit eog, output bit closes, output result_t r);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			entry_ch.valid <= 1'b0;
			@(posedge clk);
		end
		entry_ch.valid <= 1'b1;
		entry_ch.entry <= e;
		entry_ch.end_of_column <= eoc;
		entry_ch.end_of_graph <= eog;
		@(posedge clk);
		while (!entry_ch.ready)
			@(posedge clk);
		items_sent++;
		column_verdict(e, eoc, eog, closes, r);
	endtask

	// Mostly edge and loop columns with random rows and signs; the rest is
	// noise that hits invalid values, mixed and bad combinations. A few
	// columns run past row 255 to reach vertex and row saturation.
	task automatic send_graph();
		int nrows;
		int ncols;
		int len;
		int kind;
		int ra;
		int rb;
		bit closes;
		bit last;
		bit eog;
		result_t r;
		logic signed [ENTRY_W-1:0] e;
		nrows = $urandom_range(9, 2);
		ncols = $urandom_range(1) ? nrows - 1 : $urandom_range(8, 1);
		for (int c = 0; c < ncols; c++) begin
			len = ($urandom_range(79) == 0) ? $urandom_range(300, 250) : nrows;
			kind = $urandom_range(99);
			ra = $urandom_range(len - 1);
			rb = (ra + $urandom_range(len - 1, 1)) % len;
			for (int row = 0; row < len; row++) begin
				e = ENTRY_ZERO;
				if (kind < 78) begin
					if (row == ra || row == rb)
						e = $urandom_range(1) ? ENTRY_PLUS : ENTRY_MINUS;
				end else if (kind < 88) begin
					if (row == ra)
						e = ENTRY_LOOP;
				end else begin
					case ($urandom_range(5))
						0: e = ENTRY_MINUS;
						1: e = ENTRY_ZERO;
						2: e = ENTRY_PLUS;
						3: e = ENTRY_LOOP;
						default: e = ENTRY_W'($urandom_range(255));
					endcase
				end
				last = (row == len - 1);
				// stray graph-end flags on inner rows must be ignored
				eog = last ? (c == ncols - 1) : ($urandom_range(7) == 0);
				send_entry(e, last, eog, closes, r);
				if (closes)
					pending_verdicts.insert(pending_verdicts.size(), r);
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// result side: random back-pressure, compare against the oldest verdict
	always @(posedge clk) begin
		result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			columns_seen++;
			if (result_ch.graph_done)
				graphs_seen++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: result item with no expectation waiting, status %0d",
					$time, result_ch.column_status);
			end else begin
				want = pending_verdicts.pop_front();
				check_field("column_status", want.status, result_ch.column_status);
				check_field("source_vertex", want.src, result_ch.source_vertex);
				check_field("target_vertex", want.dst, result_ch.target_vertex);
				check_field("edge_directed", want.dir, result_ch.edge_directed);
				check_field("graph_done", want.done, result_ch.graph_done);
				check_field("graph_directed", want.g_directed, result_ch.graph_directed);
				check_field("graph_is_tree", want.g_tree, result_ch.graph_is_tree);
				check_field("graph_valid", want.g_valid, result_ch.graph_valid);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_verdicts.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		bit closes;
		result_t r;
		entry_ch.valid = 1'b0;
		entry_ch.entry = '0;
		entry_ch.end_of_column = 1'b0;
		entry_ch.end_of_graph = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed results go in as written, the rest from the predictor
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_entry(directed_rows[i].entry, directed_rows[i].eoc, directed_rows[i].eog,
				closes, r);
			if (closes)
				pending_verdicts.insert(pending_verdicts.size(),
					directed_rows[i].typed ? directed_rows[i].want : r);
		end

		while (items_sent < NUM_DIRECTED + RANDOM_ITEMS)
			send_graph();
		entry_ch.valid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d entry items; checked %0d column results over %0d graph ends.",
			items_sent, columns_seen, graphs_seen);
		$display("%0d field mismatches in %0d cycles.", mismatches, cycles);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
sv/icec_pkg.sv
sv/icec_if.sv
sv/icec_column_acc.sv
sv/icec_column_eval.sv
sv/incidence_column_edge_checker.sv
test/incidence_column_edge_checker_tb.sv
